@@ design/vdi_pkg.sv @@
// vdi_pkg: shared types and constants for the vertex dedup indexer
// no dependencies; used by vdi_cell, vertex_dedup_indexer and vdi_checker
package vdi_pkg;

	localparam int COMP_W      = 32;  // one float bit pattern
	localparam int FIELD_COUNT = 6;   // x, y, z, r, g, b
	localparam int INDEX_W     = 8;   // element index width on the output
	localparam int IN_DATA_W   = COMP_W * FIELD_COUNT;

	// control part of a word walking down the cell chain
	typedef struct packed {
		logic               valid;
		logic               new_mesh;
		logic               hit;      // matched a stored vertex
		logic               placed;   // stored into a free cell
		logic [INDEX_W-1:0] idx;
	} vdi_tok_t;

endpackage

@@ design/vdi_cell.sv @@
// vdi_cell: one table entry plus one stage of the search chain
// depends on vdi_pkg
module vdi_cell #(
	parameter int VEC_W    = 192,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  vdi_pkg::vdi_tok_t   tok_i,
	input  logic [VEC_W-1:0]    vec_i,
	output vdi_pkg::vdi_tok_t   tok_o,
	output logic [VEC_W-1:0]    vec_o
);

	localparam logic [vdi_pkg::INDEX_W-1:0] ID = vdi_pkg::INDEX_W'(CELL_IDX);

	logic              occupied_q;
	logic [VEC_W-1:0]  entry_q;
	vdi_pkg::vdi_tok_t tok_q;
	logic [VEC_W-1:0]  vec_q;

	logic              occ_eff;
	logic              open_search;
	logic              match;
	logic              write_en;
	vdi_pkg::vdi_tok_t tok_n;

	always_comb begin
		// a valid new-mesh word empties every cell it passes but the one it is stored in
		occ_eff     = occupied_q && !tok_i.new_mesh;
		open_search = tok_i.valid && !tok_i.hit && !tok_i.placed;
		match       = occ_eff && (entry_q == vec_i);
		write_en    = open_search && !occ_eff;
		tok_n       = tok_i;
		if (open_search && match) begin
			tok_n.hit = 1'b1;
			tok_n.idx = ID;
		end else if (write_en) begin
			tok_n.placed = 1'b1;
			tok_n.idx    = ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
			tok_q      <= '0;
		end else if (adv) begin
			tok_q <= tok_n;
			if (tok_i.valid) begin
				occupied_q <= occ_eff || write_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_q <= vec_i;
			if (write_en) begin
				entry_q <= vec_i;
			end
		end
	end

	assign tok_o = tok_q;
	assign vec_o = vec_q;

endmodule

@@ design/vertex_dedup_indexer.sv @@
// vertex_dedup_indexer: top level, a row of table cells and the output register
// depends on vdi_pkg and vdi_cell
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | comp_x..comp_b, 32 bits each   | new_mesh
//  m_*     | out | element_index                  | is_new, table_full
//
// one vertex per cycle sustained while the output is not stalled; each word
// walks the row of TABLE_DEPTH cells, one cell each time the row advances, then the output register.
// reset empties every cell (occupancy flops) and drops all words in flight.
// an output stall that is not taken freezes the whole row and s_tready.
module vertex_dedup_indexer #(
	parameter int TABLE_DEPTH = 256,
	parameter int COMPONENTS  = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vdi_pkg::IN_DATA_W-1:0] s_tdata,   // comp_x, comp_y, comp_z, comp_r, comp_g, comp_b
	input  logic                          s_tuser,   // new_mesh
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vdi_pkg::INDEX_W-1:0]   m_tdata,   // element_index
	output logic [1:0]                    m_tuser    // is_new, table_full
);

	localparam int USED  = (COMPONENTS < vdi_pkg::FIELD_COUNT) ? COMPONENTS
	                                                           : vdi_pkg::FIELD_COUNT;
	localparam int VEC_W = USED * vdi_pkg::COMP_W;

	logic                        adv;
	vdi_pkg::vdi_tok_t           tok_c [0:TABLE_DEPTH];
	logic [VEC_W-1:0]            vec_c [0:TABLE_DEPTH-1];
	logic                        out_valid_q;
	logic [vdi_pkg::INDEX_W-1:0] out_index_q;
	logic                        out_new_q;
	logic                        out_full_q;
	vdi_pkg::vdi_tok_t           last_tok;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	assign tok_c[0] = '{valid: s_tvalid, new_mesh: s_tuser, hit: 1'b0, placed: 1'b0, idx: '0};
	assign vec_c[0] = s_tdata[VEC_W-1:0];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i < TABLE_DEPTH - 1) begin : g_mid
			vdi_cell #(.VEC_W(VEC_W), .CELL_IDX(i)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.tok_i  (tok_c[i]),
				.vec_i  (vec_c[i]),
				.tok_o  (tok_c[i+1]),
				.vec_o  (vec_c[i+1])
			);
		end else begin : g_last
			vdi_cell #(.VEC_W(VEC_W), .CELL_IDX(i)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.tok_i  (tok_c[i]),
				.vec_i  (vec_c[i]),
				.tok_o  (tok_c[i+1]),
				.vec_o  ()
			);
		end
	end

	assign last_tok = tok_c[TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last_tok.valid;
		end
	end

	// no hit and no free cell means the table was full
	always_ff @(posedge clk) begin
		if (adv) begin
			out_index_q <= (last_tok.hit || last_tok.placed) ? last_tok.idx : '0;
			out_new_q   <= last_tok.placed;
			out_full_q  <= !last_tok.hit && !last_tok.placed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_index_q;
	assign m_tuser  = {out_full_q, out_new_q};

endmodule

@@ design/vdi_checker.sv @@
// vdi_checker: port-level checks for vertex_dedup_indexer, bound to the top
// depends on vdi_pkg widths only
module vdi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [vdi_pkg::INDEX_W-1:0]   m_tdata,
	input logic [1:0]                    m_tuser
);

	// a word is never both new and rejected
	a_new_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("is_new and table_full both set");

	// a rejected vertex reports index zero
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
		else $error("table_full with nonzero index");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output word changed while stalled");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
